// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, masked while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that a condition never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/nkv_pkg.sv -----
// Types, constants and helpers of the namespaced key-value table.
// No dependencies.
`timescale 1ns / 1ps
package nkv_pkg;

	localparam int ENTRY_COUNT  = 64;
	localparam int HANDLE_COUNT = 8;
	localparam int VALUE_BYTES  = 256;
	localparam int QUEUE_DEPTH  = 2;
	// staging address covers the largest word count (32)
	localparam int STAGE_AW     = 6;

	typedef enum logic [2:0] {
		OP_INIT,
		OP_ERASE,
		OP_OPEN,
		OP_CLOSE,
		OP_GET_U8,
		OP_SET_U8,
		OP_GET_BLOB,
		OP_SET_BLOB
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_INVALID,
		ST_NOT_FOUND,
		ST_FAIL
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [3:0]  handle;
		logic [63:0] name_hi;
		logic [55:0] name_lo;
		logic [8:0]  blob_length;
		logic        size_query;
		logic [63:0] data_word;
		logic        data_last;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  handle_out;
		logic [8:0]  length_out;
		logic [63:0] data_out;
		logic        last;
	} rsp_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  handle;
		logic [63:0] key_hi;
		logic [55:0] key_lo;
		logic [8:0]  blen;
		logic        sq;
		logic [7:0]  u8_data;
	} cmd_t;

	typedef struct packed {
		logic                en;
		logic [STAGE_AW-1:0] addr;
		logic [63:0]         data;
	} stg_wr_t;

	typedef struct packed {
		logic [63:0] space_hi;
		logic [55:0] space_lo;
		logic [63:0] key_hi;
		logic [55:0] key_lo;
		logic [8:0]  length;
	} meta_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_EXEC,
		B_SCAN,
		B_DECIDE,
		B_U8_OUT,
		B_BLK_RD,
		B_BLK_OUT,
		B_CP_RD,
		B_CP_WR,
		B_FIN
	} back_state_t;

	// keep the low n bytes; n of zero keeps the whole word
	function automatic logic [63:0] low_mask(input logic [2:0] n);
		logic [63:0] m;
		m = '1;
		if (n != 3'd0) begin
			m = (64'd1 << {n, 3'b000}) - 64'd1;
		end
		return m;
	endfunction

endpackage

// ----- hw/rtl/nkv_fifo.sv -----
// Small register queue used between front and back and for results.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps
module nkv_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ----- hw/rtl/nkv_front.sv -----
// Front part: takes input beats, trims names, stages set_blob words, queues commands.
// Depends on nkv_pkg.
`timescale 1ns / 1ps
module nkv_front #(
	parameter int VALUE_BYTES = nkv_pkg::VALUE_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  nkv_pkg::req_t    req,
	output logic             cmd_push,
	output nkv_pkg::cmd_t    cmd_data,
	input  logic             cmd_full,
	output nkv_pkg::stg_wr_t stg_wr,
	input  logic             blob_done
);
	localparam int WORDS = (VALUE_BYTES + 7) / 8;
	localparam int BC_W  = $clog2(WORDS + 1);

	logic [BC_W-1:0] beat_q;
	logic            blob_busy_q;
	logic            accept, is_blob, room;
	logic [119:0]    raw, trimmed;
	logic            seen;

	always_comb begin
		raw     = {req.name_lo, req.name_hi};
		trimmed = '0;
		seen    = 1'b0;
		for (int k = 0; k < 15; k++) begin
			if (raw[8*k +: 8] == 8'd0) begin
				seen = 1'b1;
			end
			if (!seen) begin
				trimmed[8*k +: 8] = raw[8*k +: 8];
			end
		end
	end

	assign full     = cmd_full | blob_busy_q;
	assign accept   = push & ~full;
	assign is_blob  = (req.operation == nkv_pkg::OP_SET_BLOB);
	assign room     = (beat_q < BC_W'(WORDS));
	assign cmd_push = accept & (~is_blob | req.data_last);

	always_comb begin
		cmd_data.op      = req.operation;
		cmd_data.handle  = req.handle;
		cmd_data.key_hi  = trimmed[63:0];
		cmd_data.key_lo  = trimmed[119:64];
		cmd_data.blen    = req.blob_length;
		cmd_data.sq      = req.size_query;
		cmd_data.u8_data = req.data_word[7:0];
		stg_wr.en        = accept & is_blob & room;
		stg_wr.addr      = nkv_pkg::STAGE_AW'(beat_q);
		stg_wr.data      = req.data_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= '0;
			blob_busy_q <= 1'b0;
		end else begin
			if (accept) begin
				if (!is_blob || req.data_last) begin
					beat_q <= '0;
				end else if (room) begin
					beat_q <= beat_q + BC_W'(1);
				end
			end
			if (cmd_push && is_blob) begin
				blob_busy_q <= 1'b1;
			end else if (blob_done) begin
				blob_busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/nkv_back.sv -----
// Back part: scans the entry table, holds handles, value and staging memories.
// Depends on nkv_pkg.
`timescale 1ns / 1ps
module nkv_back #(
	parameter int ENTRY_COUNT  = nkv_pkg::ENTRY_COUNT,
	parameter int HANDLE_COUNT = nkv_pkg::HANDLE_COUNT,
	parameter int VALUE_BYTES  = nkv_pkg::VALUE_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  nkv_pkg::cmd_t    cmd_data,
	input  nkv_pkg::stg_wr_t stg_wr,
	output logic             res_push,
	output nkv_pkg::rsp_t    res_data,
	input  logic             res_full,
	output logic             blob_done
);
	localparam int WORDS    = (VALUE_BYTES + 7) / 8;
	localparam int WW       = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IW       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam int CW       = $clog2(ENTRY_COUNT + 1);
	localparam int HW       = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
	localparam int DM_DEPTH = ENTRY_COUNT * (1 << WW);

	nkv_pkg::back_state_t state_q, state_d;
	nkv_pkg::cmd_t        cur_q;
	nkv_pkg::meta_t       meta_mem [ENTRY_COUNT];
	nkv_pkg::meta_t       meta_rd_q, meta_wdata;
	logic [63:0]          data_mem [DM_DEPTH];
	logic [63:0]          stage_mem [WORDS];
	logic [63:0]          data_rd_q, stage_rd_q, data_wdata;
	logic [IW+WW-1:0]     data_waddr, data_raddr;

	logic [63:0]             space_hi_q;
	logic [55:0]             space_lo_q;
	logic                    ready_q;
	logic [ENTRY_COUNT-1:0]  ev_q;
	logic [HANDLE_COUNT-1:0] hv_q;
	logic [63:0]             hs_hi_q [HANDLE_COUNT];
	logic [55:0]             hs_lo_q [HANDLE_COUNT];

	logic [CW-1:0] rd_idx_q;
	logic          cmp_v_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          hit_q, free_v_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, tgt;
	logic [8:0]    hit_len_q;
	logic [WW-1:0] k_q;

	logic          go, can_tgt, cmp_hit, scan_end, blk_last, cp_last;
	logic [6:0]    get_nw, set_nw;
	logic          fh_v;
	logic [HW-1:0] fh_idx, h_idx, cur_h;
	logic          h_in, cur_h_in;
	logic          meta_we, meta_re, data_we, data_re, stg_re, set_valid;

	assign go       = ~res_full;
	assign tgt      = hit_q ? hit_idx_q : free_idx_q;
	assign can_tgt  = hit_q | free_v_q;
	assign get_nw   = 7'((10'(hit_len_q) + 10'd7) >> 3);
	assign set_nw   = 7'((10'(cur_q.blen) + 10'd7) >> 3);
	assign blk_last = (7'(k_q) == get_nw - 7'd1);
	assign cp_last  = (7'(k_q) == set_nw - 7'd1);
	assign h_idx    = HW'(cmd_data.handle);
	assign h_in     = (32'(cmd_data.handle) < 32'(HANDLE_COUNT));
	assign cur_h    = HW'(cur_q.handle);
	assign cur_h_in = (32'(cur_q.handle) < 32'(HANDLE_COUNT));
	assign cmp_hit  = cmp_v_s1 & ev_q[cmp_idx_s1]
		& (meta_rd_q.space_hi == space_hi_q) & (meta_rd_q.space_lo == space_lo_q)
		& (meta_rd_q.key_hi == cur_q.key_hi) & (meta_rd_q.key_lo == cur_q.key_lo);
	assign scan_end = cmp_v_s1 & (cmp_idx_s1 == IW'(ENTRY_COUNT - 1));

	always_comb begin
		fh_v   = 1'b0;
		fh_idx = '0;
		for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
			if (!hv_q[i]) begin
				fh_v   = 1'b1;
				fh_idx = HW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			nkv_pkg::B_IDLE: begin
				if (cmd_valid) state_d = nkv_pkg::B_EXEC;
			end
			nkv_pkg::B_EXEC: begin
				case (cur_q.op)
					nkv_pkg::OP_INIT, nkv_pkg::OP_ERASE,
					nkv_pkg::OP_OPEN, nkv_pkg::OP_CLOSE: begin
						if (go) state_d = nkv_pkg::B_IDLE;
					end
					nkv_pkg::OP_SET_BLOB: begin
						if (32'(cur_q.blen) > 32'(VALUE_BYTES)) begin
							if (go) state_d = nkv_pkg::B_IDLE;
						end else begin
							state_d = nkv_pkg::B_SCAN;
						end
					end
					default: state_d = nkv_pkg::B_SCAN;
				endcase
			end
			nkv_pkg::B_SCAN: begin
				if (cmp_hit || scan_end) state_d = nkv_pkg::B_DECIDE;
			end
			nkv_pkg::B_DECIDE: begin
				case (cur_q.op)
					nkv_pkg::OP_GET_U8: begin
						if (hit_q && hit_len_q == 9'd1) state_d = nkv_pkg::B_U8_OUT;
						else if (go) state_d = nkv_pkg::B_IDLE;
					end
					nkv_pkg::OP_GET_BLOB: begin
						if (hit_q && !cur_q.sq && !(cur_q.blen < hit_len_q) && get_nw != 7'd0)
							state_d = nkv_pkg::B_BLK_RD;
						else if (go) state_d = nkv_pkg::B_IDLE;
					end
					nkv_pkg::OP_SET_BLOB: begin
						if (!can_tgt) begin
							if (go) state_d = nkv_pkg::B_IDLE;
						end else if (set_nw == 7'd0) begin
							state_d = nkv_pkg::B_FIN;
						end else begin
							state_d = nkv_pkg::B_CP_RD;
						end
					end
					default: begin
						if (go) state_d = nkv_pkg::B_IDLE;
					end
				endcase
			end
			nkv_pkg::B_U8_OUT: begin
				if (go) state_d = nkv_pkg::B_IDLE;
			end
			nkv_pkg::B_BLK_RD: state_d = nkv_pkg::B_BLK_OUT;
			nkv_pkg::B_BLK_OUT: begin
				if (go) state_d = blk_last ? nkv_pkg::B_IDLE : nkv_pkg::B_BLK_RD;
			end
			nkv_pkg::B_CP_RD: state_d = nkv_pkg::B_CP_WR;
			nkv_pkg::B_CP_WR: state_d = cp_last ? nkv_pkg::B_FIN : nkv_pkg::B_CP_RD;
			nkv_pkg::B_FIN: begin
				if (go) state_d = nkv_pkg::B_IDLE;
			end
			default: state_d = nkv_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop              = 1'b0;
		res_push             = 1'b0;
		res_data             = '0;
		res_data.status      = nkv_pkg::ST_OK;
		res_data.last        = 1'b1;
		meta_we              = 1'b0;
		meta_re              = 1'b0;
		data_we              = 1'b0;
		data_re              = 1'b0;
		stg_re               = 1'b0;
		set_valid            = 1'b0;
		data_waddr           = {tgt, k_q};
		data_raddr           = {hit_idx_q, k_q};
		data_wdata           = stage_rd_q;
		meta_wdata.space_hi  = space_hi_q;
		meta_wdata.space_lo  = space_lo_q;
		meta_wdata.key_hi    = cur_q.key_hi;
		meta_wdata.key_lo    = cur_q.key_lo;
		meta_wdata.length    = (cur_q.op == nkv_pkg::OP_SET_U8) ? 9'd1 : cur_q.blen;
		case (state_q)
			nkv_pkg::B_IDLE: cmd_pop = cmd_valid;
			nkv_pkg::B_EXEC: begin
				case (cur_q.op)
					nkv_pkg::OP_INIT, nkv_pkg::OP_ERASE, nkv_pkg::OP_CLOSE: res_push = go;
					nkv_pkg::OP_OPEN: begin
						res_push = go;
						if (fh_v) res_data.handle_out = 3'(fh_idx);
						else res_data.status = nkv_pkg::ST_FAIL;
					end
					nkv_pkg::OP_SET_BLOB: begin
						if (32'(cur_q.blen) > 32'(VALUE_BYTES)) begin
							res_push        = go;
							res_data.status = nkv_pkg::ST_INVALID;
						end
					end
					default: ;
				endcase
			end
			nkv_pkg::B_SCAN: meta_re = (rd_idx_q < CW'(ENTRY_COUNT));
			nkv_pkg::B_DECIDE: begin
				case (cur_q.op)
					nkv_pkg::OP_GET_U8: begin
						if (!hit_q) begin
							res_push        = go;
							res_data.status = nkv_pkg::ST_NOT_FOUND;
						end else if (hit_len_q != 9'd1) begin
							res_push        = go;
							res_data.status = nkv_pkg::ST_FAIL;
						end else begin
							data_re    = 1'b1;
							data_raddr = {hit_idx_q, WW'(0)};
						end
					end
					nkv_pkg::OP_SET_U8: begin
						res_push = go;
						if (!can_tgt) begin
							res_data.status = nkv_pkg::ST_FAIL;
						end else begin
							meta_we    = go;
							data_we    = go;
							set_valid  = go;
							data_waddr = {tgt, WW'(0)};
							data_wdata = {56'd0, cur_q.u8_data};
						end
					end
					nkv_pkg::OP_GET_BLOB: begin
						if (!hit_q) begin
							res_push        = go;
							res_data.status = nkv_pkg::ST_NOT_FOUND;
						end else if (cur_q.sq) begin
							res_push            = go;
							res_data.length_out = hit_len_q;
						end else if (cur_q.blen < hit_len_q) begin
							res_push        = go;
							res_data.status = nkv_pkg::ST_INVALID;
						end else if (get_nw == 7'd0) begin
							res_push = go;
						end
					end
					default: begin
						if (!can_tgt) begin
							res_push        = go;
							res_data.status = nkv_pkg::ST_FAIL;
						end
					end
				endcase
			end
			nkv_pkg::B_U8_OUT: begin
				res_push          = go;
				res_data.data_out = {56'd0, data_rd_q[7:0]};
			end
			nkv_pkg::B_BLK_RD: data_re = 1'b1;
			nkv_pkg::B_BLK_OUT: begin
				res_push            = go;
				res_data.length_out = hit_len_q;
				res_data.data_out   = blk_last ?
					(data_rd_q & nkv_pkg::low_mask(hit_len_q[2:0])) : data_rd_q;
				res_data.last       = blk_last;
			end
			nkv_pkg::B_CP_RD: stg_re = 1'b1;
			nkv_pkg::B_CP_WR: data_we = 1'b1;
			nkv_pkg::B_FIN: begin
				res_push  = go;
				meta_we   = go;
				set_valid = go;
			end
			default: ;
		endcase
		// every finished set_blob transfer ends with exactly one result beat
		blob_done = res_push & (cur_q.op == nkv_pkg::OP_SET_BLOB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nkv_pkg::B_IDLE;
			ready_q  <= 1'b0;
			ev_q     <= '0;
			hv_q     <= '0;
			rd_idx_q <= '0;
			cmp_v_s1 <= 1'b0;
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
			k_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == nkv_pkg::B_EXEC) begin
				rd_idx_q <= '0;
				cmp_v_s1 <= 1'b0;
				hit_q    <= 1'b0;
				free_v_q <= 1'b0;
				if (go) begin
					case (cur_q.op)
						nkv_pkg::OP_INIT: begin
							if (!ready_q) begin
								ev_q <= '0;
								hv_q <= '0;
							end
							ready_q <= 1'b1;
						end
						nkv_pkg::OP_ERASE: ev_q <= '0;
						nkv_pkg::OP_OPEN: begin
							if (fh_v) hv_q[fh_idx] <= 1'b1;
						end
						nkv_pkg::OP_CLOSE: begin
							if (cur_h_in) hv_q[cur_h] <= 1'b0;
						end
						default: ;
					endcase
				end
			end
			if (state_q == nkv_pkg::B_SCAN) begin
				cmp_v_s1 <= meta_re;
				if (meta_re) rd_idx_q <= rd_idx_q + CW'(1);
				if (cmp_v_s1 && !ev_q[cmp_idx_s1] && !free_v_q) free_v_q <= 1'b1;
				if (cmp_hit) hit_q <= 1'b1;
			end
			if (set_valid) ev_q[tgt] <= 1'b1;
			if (state_q == nkv_pkg::B_DECIDE) begin
				k_q <= '0;
			end else if ((state_q == nkv_pkg::B_BLK_OUT && go) || state_q == nkv_pkg::B_CP_WR) begin
				k_q <= k_q + WW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd_data;
			if (h_in && hv_q[h_idx]) begin
				space_hi_q <= hs_hi_q[h_idx];
				space_lo_q <= hs_lo_q[h_idx];
			end else begin
				space_hi_q <= '0;
				space_lo_q <= '0;
			end
		end
		if (state_q == nkv_pkg::B_EXEC && cur_q.op == nkv_pkg::OP_OPEN && go && fh_v) begin
			hs_hi_q[fh_idx] <= cur_q.key_hi;
			hs_lo_q[fh_idx] <= cur_q.key_lo;
		end
		if (state_q == nkv_pkg::B_SCAN) begin
			cmp_idx_s1 <= IW'(rd_idx_q);
			if (cmp_v_s1 && !ev_q[cmp_idx_s1] && !free_v_q) free_idx_q <= cmp_idx_s1;
			if (cmp_hit) begin
				hit_idx_q <= cmp_idx_s1;
				hit_len_q <= meta_rd_q.length;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[tgt] <= meta_wdata;
		if (meta_re) meta_rd_q <= meta_mem[IW'(rd_idx_q)];
	end

	always_ff @(posedge clk) begin
		if (data_we) data_mem[data_waddr] <= data_wdata;
		if (data_re) data_rd_q <= data_mem[data_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_wr.en) stage_mem[stg_wr.addr[WW-1:0]] <= stg_wr.data;
		if (stg_re) stage_rd_q <= stage_mem[k_q];
	end

endmodule

// ----- hw/rtl/namespaced_key_value_table_top.sv -----
// Top level of the namespaced key-value table: front, command queue, back, result queue.
// Depends on nkv_pkg, nkv_fifo, nkv_front, nkv_back.
//
// Input channel: push/full with one req beat per item; an item is taken when push is
// high and full is low. Result channel: empty/pop with one rsp beat per result; the
// oldest result sits on rsp while empty is low and leaves when pop is high.
// Every item but a set_blob beat without data_last gives one or more results; the
// final one of an item has last set. get_blob gives one beat per stored 8-byte word.
// Lookups and set operations scan the entry table one entry per cycle, stopping early
// on a hit; init, erase, open and close skip the scan. get_blob reads and then sends
// each stored word in turn, and set_blob reads each staged word and then writes it
// into the value memory before the result is given.
// The entry scan over the metadata memory sets the throughput: one item at a time.
// full also stays high while a finished set_blob transfer is being written back.
// Reset clears all entry and handle valid bits and the queues at once; no sweep runs.
// When the receiver stops popping, the result queue fills, the back part waits, the
// command queue fills and full rises; nothing is dropped.
`timescale 1ns / 1ps
module namespaced_key_value_table_top #(
	parameter int ENTRY_COUNT  = nkv_pkg::ENTRY_COUNT,
	parameter int HANDLE_COUNT = nkv_pkg::HANDLE_COUNT,
	parameter int VALUE_BYTES  = nkv_pkg::VALUE_BYTES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  nkv_pkg::req_t req,
	output logic          empty,
	input  logic          pop,
	output nkv_pkg::rsp_t rsp
);
	nkv_pkg::cmd_t    cmd_wdata, cmd_rdata;
	nkv_pkg::rsp_t    res_data;
	nkv_pkg::stg_wr_t stg_wr;
	logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
	logic             res_push, res_full, blob_done;

	nkv_front #(
		.VALUE_BYTES(VALUE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req      (req),
		.cmd_push (cmd_push),
		.cmd_data (cmd_wdata),
		.cmd_full (cmd_full),
		.stg_wr   (stg_wr),
		.blob_done(blob_done)
	);

	nkv_fifo #(
		.T    (nkv_pkg::cmd_t),
		.DEPTH(nkv_pkg::QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data(cmd_wdata),
		.full   (cmd_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd_rdata),
		.empty  (cmd_empty)
	);

	nkv_back #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.HANDLE_COUNT(HANDLE_COUNT),
		.VALUE_BYTES (VALUE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(~cmd_empty),
		.cmd_pop  (cmd_pop),
		.cmd_data (cmd_rdata),
		.stg_wr   (stg_wr),
		.res_push (res_push),
		.res_data (res_data),
		.res_full (res_full),
		.blob_done(blob_done)
	);

	nkv_fifo #(
		.T    (nkv_pkg::rsp_t),
		.DEPTH(nkv_pkg::QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_data),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(rsp),
		.empty  (empty)
	);

endmodule

// ----- hw/rtl/nkv_checker.sv -----
// Port-level checks of the key-value table, bound to the top level.
// Depends on nkv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nkv_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input nkv_pkg::req_t req,
	input logic          empty,
	input logic          pop,
	input nkv_pkg::rsp_t rsp
);
	`ASSERT_CLK(a_err_single, clk, arst_n, (!empty && rsp.status != nkv_pkg::ST_OK) |-> rsp.last, "error result not final")
	`ASSERT_CLK(a_handle_beat, clk, arst_n, (!empty && rsp.handle_out != 3'd0) |-> (rsp.status == nkv_pkg::ST_OK && rsp.length_out == 9'd0 && rsp.last), "bad open result")
	`ASSERT_NEVER(a_multi_len, clk, arst_n, !empty && !rsp.last && (rsp.status != nkv_pkg::ST_OK || rsp.length_out == 9'd0), "multi-beat result without length")
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, (!empty && !pop) |=> (!empty && $stable(rsp)), "result changed while waiting")

endmodule

bind namespaced_key_value_table_top nkv_checker u_nkv_checker (.*);

// ----- bench/namespaced_key_value_table_top_tb.sv -----
// Testbench for namespaced_key_value_table_top: directed and random table traffic,
// results predicted in the bench and checked beat by beat against the result queue.
// Depends on nkv_pkg and the RTL of namespaced_key_value_table_top.
`timescale 1ns / 1ps
module namespaced_key_value_table_top_tb;

	localparam int NWORDS = nkv_pkg::VALUE_BYTES / 8;
	localparam int IDLE_LIMIT = 20000;

	logic           clk;
	logic           arst_n;
	logic           push;
	logic           full;
	nkv_pkg::req_t  req;
	logic           empty;
	logic           pop;
	nkv_pkg::rsp_t  rsp;

	namespaced_key_value_table_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// table shadow
	logic        ent_valid[nkv_pkg::ENTRY_COUNT];
	logic [63:0] ent_space_hi[nkv_pkg::ENTRY_COUNT];
	logic [55:0] ent_space_lo[nkv_pkg::ENTRY_COUNT];
	logic [63:0] ent_key_hi[nkv_pkg::ENTRY_COUNT];
	logic [55:0] ent_key_lo[nkv_pkg::ENTRY_COUNT];
	logic [8:0]  ent_len[nkv_pkg::ENTRY_COUNT];
	logic [63:0] ent_words[nkv_pkg::ENTRY_COUNT][NWORDS];
	logic        hnd_valid[nkv_pkg::HANDLE_COUNT];
	logic [63:0] hnd_space_hi[nkv_pkg::HANDLE_COUNT];
	logic [55:0] hnd_space_lo[nkv_pkg::HANDLE_COUNT];
	logic        table_ready;
	logic [63:0] staged[NWORDS];
	int          beats_staged;
	int          staged_max;

	nkv_pkg::rsp_t expected_rsps[$];
	int   errors;
	int   burst_left;
	logic hold_req;
	int   hold_cnt;
	int   pop_cyc;
	int   idle_cycles;
	logic [63:0] pool_hi[6];
	logic [55:0] pool_lo[6];

	function automatic void canon_name(inout logic [63:0] hi, inout logic [55:0] lo);
		logic [119:0] v;
		logic         cut;
		v = {lo, hi};
		cut = 1'b0;
		for (int k = 0; k < 15; k++) begin
			if (v[8*k +: 8] == 8'd0) begin
				cut = 1'b1;
			end
			if (cut) begin
				v[8*k +: 8] = 8'd0;
			end
		end
		hi = v[63:0];
		lo = v[119:64];
	endfunction

	function automatic int lookup_slot(logic [63:0] shi, logic [55:0] slo,
			logic [63:0] khi, logic [55:0] klo);
		for (int i = 0; i < nkv_pkg::ENTRY_COUNT; i++) begin
			if (ent_valid[i] && ent_space_hi[i] == shi && ent_space_lo[i] == slo &&
					ent_key_hi[i] == khi && ent_key_lo[i] == klo) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int find_or_claim(logic [63:0] shi, logic [55:0] slo,
			logic [63:0] khi, logic [55:0] klo);
		int i;
		i = lookup_slot(shi, slo, khi, klo);
		if (i >= 0) begin
			return i;
		end
		for (int j = 0; j < nkv_pkg::ENTRY_COUNT; j++) begin
			if (!ent_valid[j]) begin
				ent_valid[j] = 1'b1;
				ent_space_hi[j] = shi;
				ent_space_lo[j] = slo;
				ent_key_hi[j] = khi;
				ent_key_lo[j] = klo;
				ent_len[j] = '0;
				return j;
			end
		end
		return -1;
	endfunction

	function automatic void clear_entries();
		for (int i = 0; i < nkv_pkg::ENTRY_COUNT; i++) begin
			ent_valid[i] = 1'b0;
			ent_space_hi[i] = '0;
			ent_space_lo[i] = '0;
			ent_key_hi[i] = '0;
			ent_key_lo[i] = '0;
			ent_len[i] = '0;
		end
	endfunction

	function automatic void add_rsp(nkv_pkg::status_t s, logic [2:0] h, logic [8:0] len,
			logic [63:0] d, logic l);
		nkv_pkg::rsp_t x;
		x.status = s;
		x.handle_out = h;
		x.length_out = len;
		x.data_out = d;
		x.last = l;
		expected_rsps.push_back(x);
	endfunction

	function automatic void predict_table(nkv_pkg::req_t r);
		logic [63:0] khi;
		logic [55:0] klo;
		logic [63:0] shi;
		logic [55:0] slo;
		logic [63:0] w;
		int idx;
		int len;
		int nw;
		int left;
		logic done;
		khi = r.name_hi;
		klo = r.name_lo;
		canon_name(khi, klo);
		if (r.operation != nkv_pkg::OP_SET_BLOB) begin
			beats_staged = 0;
		end
		shi = '0;
		slo = '0;
		if (r.handle < nkv_pkg::HANDLE_COUNT && hnd_valid[r.handle]) begin
			shi = hnd_space_hi[r.handle];
			slo = hnd_space_lo[r.handle];
		end
		case (r.operation)
			nkv_pkg::OP_INIT: begin
				if (!table_ready) begin
					clear_entries();
					for (int i = 0; i < nkv_pkg::HANDLE_COUNT; i++) begin
						hnd_valid[i] = 1'b0;
						hnd_space_hi[i] = '0;
						hnd_space_lo[i] = '0;
					end
					table_ready = 1'b1;
				end
				add_rsp(nkv_pkg::ST_OK, 0, 0, 0, 1);
			end
			nkv_pkg::OP_ERASE: begin
				clear_entries();
				add_rsp(nkv_pkg::ST_OK, 0, 0, 0, 1);
			end
			nkv_pkg::OP_OPEN: begin
				done = 1'b0;
				for (int i = 0; i < nkv_pkg::HANDLE_COUNT && !done; i++) begin
					if (!hnd_valid[i]) begin
						hnd_valid[i] = 1'b1;
						hnd_space_hi[i] = khi;
						hnd_space_lo[i] = klo;
						add_rsp(nkv_pkg::ST_OK, 3'(i), 0, 0, 1);
						done = 1'b1;
					end
				end
				if (!done) begin
					add_rsp(nkv_pkg::ST_FAIL, 0, 0, 0, 1);
				end
			end
			nkv_pkg::OP_CLOSE: begin
				if (r.handle < nkv_pkg::HANDLE_COUNT) begin
					hnd_valid[r.handle] = 1'b0;
				end
				add_rsp(nkv_pkg::ST_OK, 0, 0, 0, 1);
			end
			nkv_pkg::OP_GET_U8: begin
				idx = lookup_slot(shi, slo, khi, klo);
				if (idx < 0) begin
					add_rsp(nkv_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
				end else if (ent_len[idx] != 1) begin
					add_rsp(nkv_pkg::ST_FAIL, 0, 0, 0, 1);
				end else begin
					add_rsp(nkv_pkg::ST_OK, 0, 0, {56'd0, ent_words[idx][0][7:0]}, 1);
				end
			end
			nkv_pkg::OP_SET_U8: begin
				idx = find_or_claim(shi, slo, khi, klo);
				if (idx < 0) begin
					add_rsp(nkv_pkg::ST_FAIL, 0, 0, 0, 1);
				end else begin
					ent_words[idx][0] = {56'd0, r.data_word[7:0]};
					ent_len[idx] = 9'd1;
					add_rsp(nkv_pkg::ST_OK, 0, 0, 0, 1);
				end
			end
			nkv_pkg::OP_GET_BLOB: begin
				idx = lookup_slot(shi, slo, khi, klo);
				if (idx < 0) begin
					add_rsp(nkv_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
				end else begin
					len = int'(ent_len[idx]);
					nw = (len + 7) / 8;
					if (r.size_query) begin
						add_rsp(nkv_pkg::ST_OK, 0, 9'(len), 0, 1);
					end else if (int'(r.blob_length) < len) begin
						add_rsp(nkv_pkg::ST_INVALID, 0, 0, 0, 1);
					end else if (nw == 0) begin
						add_rsp(nkv_pkg::ST_OK, 0, 0, 0, 1);
					end else begin
						for (int k = 0; k < nw; k++) begin
							w = ent_words[idx][k];
							left = len - 8 * k;
							if (left < 8) begin
								w = w & ((64'd1 << (8 * left)) - 64'd1);
							end
							add_rsp(nkv_pkg::ST_OK, 0, 9'(len), w, k + 1 == nw);
						end
					end
				end
			end
			default: begin
				if (beats_staged < NWORDS) begin
					staged[beats_staged] = r.data_word;
					beats_staged++;
					if (beats_staged > staged_max) begin
						staged_max = beats_staged;
					end
				end
				if (r.data_last) begin
					beats_staged = 0;
					if (int'(r.blob_length) > nkv_pkg::VALUE_BYTES) begin
						add_rsp(nkv_pkg::ST_INVALID, 0, 0, 0, 1);
					end else begin
						idx = find_or_claim(shi, slo, khi, klo);
						if (idx < 0) begin
							add_rsp(nkv_pkg::ST_FAIL, 0, 0, 0, 1);
						end else begin
							nw = (int'(r.blob_length) + 7) / 8;
							for (int k = 0; k < nw; k++) begin
								ent_words[idx][k] = staged[k];
							end
							ent_len[idx] = r.blob_length;
							add_rsp(nkv_pkg::ST_OK, 0, 0, 0, 1);
						end
					end
				end
			end
		endcase
	endfunction

	function automatic nkv_pkg::req_t mk(nkv_pkg::op_t op, int h, logic [63:0] hi,
			logic [55:0] lo, int blen, logic sq, logic [63:0] dw, logic dl);
		nkv_pkg::req_t r;
		r.operation = op;
		r.handle = 4'(h);
		r.name_hi = hi;
		r.name_lo = lo;
		r.blob_length = 9'(blen);
		r.size_query = sq;
		r.data_word = dw;
		r.data_last = dl;
		return r;
	endfunction

	task automatic send(nkv_pkg::req_t r);
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		predict_table(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 6);
			if ($urandom_range(0, 2) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// pool name, at times with random bytes behind its terminator
	task automatic pick_name(output logic [63:0] hi, output logic [55:0] lo);
		logic [119:0] v;
		logic [127:0] junk;
		int p;
		int n;
		p = $urandom_range(0, 5);
		v = {pool_lo[p], pool_hi[p]};
		junk = {$urandom(), $urandom(), $urandom(), $urandom()};
		n = 15;
		for (int k = 14; k >= 0; k--) begin
			if (v[8*k +: 8] == 8'd0) begin
				n = k;
			end
		end
		if (n < 14 && $urandom_range(0, 1)) begin
			for (int k = n + 1; k < 15; k++) begin
				v[8*k +: 8] = junk[8*k +: 8];
			end
		end
		hi = v[63:0];
		lo = v[119:64];
	endtask

	task automatic send_blob(int h, logic [63:0] hi, logic [55:0] lo, int beats, int blen);
		for (int b = 0; b < beats; b++) begin
			send(mk(nkv_pkg::OP_SET_BLOB, h, hi, lo, blen, 1'($urandom_range(0, 1)),
				{$urandom(), $urandom()}, b == beats - 1));
		end
	endtask

	task automatic test_basic_ops();
		send(mk(nkv_pkg::OP_GET_U8, 3, 64'h41, 0, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_SET_U8, 3, 64'h41, 0, 0, 0, 64'hFF, 0));
		send(mk(nkv_pkg::OP_INIT, 0, 0, 0, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_INIT, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < 9; i++) begin
			send(mk(nkv_pkg::OP_OPEN, 0, {56'd0, 8'(8'h61 + i)}, 0, 0, 0, 0, 0));
		end
		send(mk(nkv_pkg::OP_CLOSE, 2, 0, 0, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_CLOSE, 12, 0, 0, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_OPEN, 0, '1, '1, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_SET_U8, 2, '1, '1, 0, 0, 64'hA5, 0));
		send(mk(nkv_pkg::OP_GET_U8, 2, '1, {8'h00, 48'hFFFF_FFFF_FFFF}, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_GET_U8, 2, '1, '1, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_SET_U8, 15, 64'h4B, 0, 0, 0, 64'h5A, 0));
		send(mk(nkv_pkg::OP_GET_U8, 9, 64'h4B, 0, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_GET_BLOB, 9, 64'h4B, 0, 0, 1, 0, 0));
		drain();
	endtask

	task automatic test_blob_edges();
		// one beat past the staging depth, full-size value
		send_blob(1, 64'h42, 0, 33, 256);
		send(mk(nkv_pkg::OP_GET_BLOB, 1, 64'h42, 0, 255, 0, 0, 0));
		send(mk(nkv_pkg::OP_GET_BLOB, 1, 64'h42, 0, 511, 0, 0, 0));
		send(mk(nkv_pkg::OP_GET_U8, 1, 64'h42, 0, 0, 0, 0, 0));
		// short transfer reuses older staged words
		send_blob(1, 64'h43, 0, 1, 13);
		send(mk(nkv_pkg::OP_GET_BLOB, 1, 64'h43, 0, 13, 0, 0, 0));
		send_blob(1, 64'h44, 0, 1, 0);
		send(mk(nkv_pkg::OP_GET_BLOB, 1, 64'h44, 0, 0, 0, 0, 0));
		send_blob(1, 64'h45, 0, 1, 257);
		send_blob(1, 64'h45, 0, 1, 511);
		send(mk(nkv_pkg::OP_GET_BLOB, 1, 64'h45, 0, 0, 1, 0, 0));
		send_blob(1, 64'h46, 0, 2, 0);
		send(mk(nkv_pkg::OP_SET_BLOB, 1, 64'h46, 0, 0, 0, 64'h1234, 0));
		send(mk(nkv_pkg::OP_ERASE, 0, 0, 0, 0, 0, 0, 0));
		send_blob(1, 64'h46, 0, 1, 200);
		send(mk(nkv_pkg::OP_GET_BLOB, 1, 64'h46, 0, 200, 0, 0, 0));
		drain();
	endtask

	task automatic test_table_full();
		send(mk(nkv_pkg::OP_ERASE, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < nkv_pkg::ENTRY_COUNT; i++) begin
			send(mk(nkv_pkg::OP_SET_U8, 15, 64'(i + 1), 0, 0, 0, 64'(i), 0));
		end
		send(mk(nkv_pkg::OP_SET_U8, 15, 64'h1FF, 0, 0, 0, 0, 0));
		send_blob(15, 64'h1FF, 0, 1, 8);
		send(mk(nkv_pkg::OP_SET_U8, 15, 64'd7, 0, 0, 0, 64'h77, 0));
		send(mk(nkv_pkg::OP_GET_U8, 15, 64'd7, 0, 0, 0, 0, 0));
		send(mk(nkv_pkg::OP_ERASE, 0, 0, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 6; i++) begin
			send(mk(nkv_pkg::OP_SET_U8, 15, 64'h50 + 64'(i), 0, 0, 0,
				{$urandom(), $urandom()}, 0));
		end
		drain();
	endtask

	task automatic test_random_traffic();
		logic [63:0] hi;
		logic [55:0] lo;
		int n;
		int h;
		int beats;
		int limit;
		n = 0;
		while (n < 12) begin
			pick_name(hi, lo);
			h = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 2);
			case ($urandom_range(0, 15))
				0: send(mk(nkv_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 15), hi, lo,
					$urandom_range(0, 511), 1'($urandom_range(0, 1)), {$urandom(), $urandom()},
					1'($urandom_range(0, 1))));
				1, 2: send(mk(nkv_pkg::OP_SET_U8, h, hi, lo, $urandom_range(0, 511), 0,
					{$urandom(), $urandom()}, 1'($urandom_range(0, 1))));
				3, 4: send(mk(nkv_pkg::OP_GET_U8, h, hi, lo, 0, 0, 0, 0));
				5, 6, 7, 8: send(mk(nkv_pkg::OP_GET_BLOB, h, hi, lo, $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 511) : 256, $urandom_range(0, 4) == 0, 0, 0));
				9: begin
					// broken transfer
					send(mk(nkv_pkg::OP_SET_BLOB, h, hi, lo, 0, 0, {$urandom(), $urandom()}, 0));
					send(mk(nkv_pkg::OP_GET_U8, h, hi, lo, 0, 0, 0, 0));
				end
				default: begin
					beats = $urandom_range(0, 4) == 0 ? $urandom_range(5, 12) :
						$urandom_range(1, 4);
					limit = (staged_max > beats ? staged_max : beats) * 8;
					if (limit > nkv_pkg::VALUE_BYTES) begin
						limit = nkv_pkg::VALUE_BYTES;
					end
					send_blob(h, hi, lo, beats, $urandom_range(0, 9) == 0 ?
						$urandom_range(257, 511) : $urandom_range(0, limit));
					n += beats - 1;
				end
			endcase
			n++;
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result beat %p", rsp);
				errors++;
			end else begin
				nkv_pkg::rsp_t x;
				x = expected_rsps.pop_front();
				if (rsp.status !== x.status) begin
					$error("status exp %0d got %0d", x.status, rsp.status);
					errors++;
				end
				if (rsp.handle_out !== x.handle_out) begin
					$error("handle_out exp %0d got %0d", x.handle_out, rsp.handle_out);
					errors++;
				end
				if (rsp.length_out !== x.length_out) begin
					$error("length_out exp %0d got %0d", x.length_out, rsp.length_out);
					errors++;
				end
				if (rsp.data_out !== x.data_out) begin
					$error("data_out exp %h got %h", x.data_out, rsp.data_out);
					errors++;
				end
				if (rsp.last !== x.last) begin
					$error("last exp %0d got %0d", x.last, rsp.last);
					errors++;
				end
			end
		end
		pop_cyc++;
		if (hold_cnt > 0) begin
			hold_cnt--;
			pop <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 400;
			pop <= 1'b0;
		end else begin
			case (pop_cyc[8:7])
				2'd0: pop <= 1'b1;
				2'd1: pop <= 1'($urandom_range(0, 1));
				2'd2: pop <= (pop_cyc % 3) == 0;
				default: pop <= $urandom_range(0, 3) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL namespaced_key_value_table_top");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		req = '0;
		errors = 0;
		burst_left = 0;
		hold_req = 1'b0;
		hold_cnt = 0;
		pop_cyc = 0;
		idle_cycles = 0;
		table_ready = 1'b0;
		beats_staged = 0;
		staged_max = 0;
		clear_entries();
		for (int i = 0; i < nkv_pkg::HANDLE_COUNT; i++) begin
			hnd_valid[i] = 1'b0;
			hnd_space_hi[i] = '0;
			hnd_space_lo[i] = '0;
		end
		for (int i = 0; i < NWORDS; i++) begin
			staged[i] = '0;
		end
		for (int p = 0; p < 6; p++) begin
			pool_hi[p] = {$urandom() | 32'h0101_0101, $urandom() | 32'h0101_0101};
			pool_lo[p] = {24'($urandom()) | 24'h01_0101, $urandom() | 32'h0101_0101};
		end
		pool_hi[0][15:8] = 8'd0;
		pool_lo[1][7:0] = 8'd0;
		pool_hi[2] = '0;
		pool_lo[2] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_blob_edges();
		test_table_full();
		test_backpressure();
		test_random_traffic();
		if (errors == 0) begin
			$display("PASS namespaced_key_value_table_top");
		end else begin
			$display("FAIL namespaced_key_value_table_top");
		end
		$finish;
	end

endmodule
